// ===== rtl/core/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants, widths and command codes for the Prim spanning tree block.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int MAX_NODES  = 64;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int NODE_W     = 7;
    localparam int WEIGHT_W   = 32;
    localparam int COST_W     = 40;
    localparam int SLOT_W     = 2 * IDX_W;
    localparam int EDGE_DEPTH = 1 << SLOT_W;
    localparam int EDGE_W     = WEIGHT_W + 1;
    localparam int FUNC_W     = 2;
    localparam int S_DATA_W   = ((2 * NODE_W + WEIGHT_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((NODE_W + COST_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - NODE_W - COST_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

endpackage

// ===== rtl/core/mst_ram.sv =====
// ----------------------------------------------------------------------------
// mst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int  DATA_W = 32,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/min_spanning_tree_prim.sv =====
// ----------------------------------------------------------------------------
// min_spanning_tree_prim
// Edge store plus Prim tree builder that emits nodes in visiting order.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the command (add edge, run, clear), s_tdata
// carries the edge endpoints and signed weight. Output stream: one transaction
// per node added to the tree, m_tdata holds node and running cost, m_tlast
// marks the final node of node 1's component.
// Sequencing: an add reads the edge RAM entry, then compares and writes it
// (the write only when the entry is empty or the new weight is lower). A clear
// sweeps the edge RAM one entry a cycle. A run visits at most 64 nodes; each
// node costs one scan over all 64 candidates through the edge RAM and link
// RAM read ports, plus an emit step. s_tready is low for the whole of each
// accepted add, run and clear; invalid adds and the spare code are dropped.
// Reset: the block runs the same clearing pass over the edge RAM and holds
// s_tready low until it is done.
// Stall: results sit in an output register; while it is full and m_tready is
// low, the sequencer holds before emitting the next node.
// ----------------------------------------------------------------------------
module min_spanning_tree_prim (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // node_a [6:0], node_b [13:7], weight [45:14], zero fill
    input  logic [mst_pkg::S_DATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [mst_pkg::FUNC_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // node [6:0], total_cost [46:7], zero fill
    output logic [mst_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);

    import mst_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [WEIGHT_W-1:0]   add_w_reg, add_w_next;
    logic [MAX_NODES-1:0]  visited_reg, visited_next;
    logic [MAX_NODES-1:0]  link_valid_reg, link_valid_next;
    logic [IDX_W-1:0]      u_reg, u_next;
    logic [COST_W-1:0]     cost_reg, cost_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [IDX_W:0]        cnt_reg, cnt_next;
    logic                  proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]      proc_idx_reg, proc_idx_next;
    logic                  pick_vld_reg, pick_vld_next;
    logic [IDX_W-1:0]      pick_idx_reg, pick_idx_next;
    logic [WEIGHT_W-1:0]   pick_w_reg, pick_w_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [NODE_W-1:0]     m_node_reg, m_node_next;
    logic [COST_W-1:0]     m_cost_reg, m_cost_next;
    logic                  m_last_reg, m_last_next;

    logic                  edge_wr_en;
    logic [SLOT_W-1:0]     edge_wr_addr;
    logic [EDGE_W-1:0]     edge_wr_data;
    logic [SLOT_W-1:0]     edge_rd_addr;
    logic [EDGE_W-1:0]     edge_rd_data;
    logic                  best_wr_en;
    logic [IDX_W-1:0]      best_wr_addr;
    logic [WEIGHT_W-1:0]   best_wr_data;
    logic [IDX_W-1:0]      best_rd_addr;
    logic [WEIGHT_W-1:0]   best_rd_data;

    logic [NODE_W-1:0]     in_a, in_b, in_a_m1, in_b_m1;
    logic [IDX_W-1:0]      a_idx, b_idx, scan_idx;
    logic                  add_ok;
    logic                  scan_issue;
    logic                  out_free;
    logic                  last_now;
    logic                  p_vis, p_lv, p_present, p_relax, p_new_lv, p_cand;
    logic [WEIGHT_W-1:0]   p_edge_w, p_new_w;

    mst_ram #(.DATA_W(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_wr_addr),
        .wr_data (edge_wr_data),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    mst_ram #(.DATA_W(WEIGHT_W), .DEPTH(MAX_NODES)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (best_wr_en),
        .wr_addr (best_wr_addr),
        .wr_data (best_wr_data),
        .rd_addr (best_rd_addr),
        .rd_data (best_rd_data)
    );

    assign in_a     = s_tdata[NODE_W-1:0];
    assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
    assign in_a_m1  = in_a - NODE_W'(1);
    assign in_b_m1  = in_b - NODE_W'(1);
    assign a_idx    = in_a_m1[IDX_W-1:0];
    assign b_idx    = in_b_m1[IDX_W-1:0];
    assign add_ok   = (in_a != '0) && (in_a <= NODE_W'(MAX_NODES))
                   && (in_b != '0) && (in_b <= NODE_W'(MAX_NODES))
                   && (in_a != in_b);
    assign scan_idx   = cnt_reg[IDX_W-1:0];
    assign scan_issue = (cnt_reg != (IDX_W+1)'(MAX_NODES));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_now   = !pick_vld_reg || (step_reg == IDX_W'(MAX_NODES - 1));

    assign p_vis     = visited_reg[proc_idx_reg];
    assign p_lv      = link_valid_reg[proc_idx_reg];
    assign p_present = edge_rd_data[EDGE_W-1];
    assign p_edge_w  = edge_rd_data[WEIGHT_W-1:0];
    assign p_relax   = !p_vis && p_present
                    && (!p_lv || ($signed(p_edge_w) < $signed(best_rd_data)));
    assign p_new_w   = p_relax ? p_edge_w : best_rd_data;
    assign p_new_lv  = p_lv || (!p_vis && p_present);
    assign p_cand    = !p_vis && p_new_lv
                    && (!pick_vld_reg || ($signed(p_new_w) < $signed(pick_w_reg)));

    always_comb begin
        edge_rd_addr = slot_reg;
        if (state_reg == ST_SCAN) begin
            edge_rd_addr = (u_reg < scan_idx) ? {u_reg, scan_idx} : {scan_idx, u_reg};
        end
    end
    assign best_rd_addr = scan_idx;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        slot_next       = slot_reg;
        add_w_next      = add_w_reg;
        visited_next    = visited_reg;
        link_valid_next = link_valid_reg;
        u_next          = u_reg;
        cost_next       = cost_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        proc_vld_next   = proc_vld_reg;
        proc_idx_next   = proc_idx_reg;
        pick_vld_next   = pick_vld_reg;
        pick_idx_next   = pick_idx_reg;
        pick_w_next     = pick_w_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_node_next     = m_node_reg;
        m_cost_next     = m_cost_reg;
        m_last_next     = m_last_reg;
        edge_wr_en      = 1'b0;
        edge_wr_addr    = clr_addr_reg;
        edge_wr_data    = '0;
        best_wr_en      = 1'b0;
        best_wr_addr    = proc_idx_reg;
        best_wr_data    = p_new_w;

        unique case (state_reg)
            ST_CLEAR: begin
                edge_wr_en = 1'b1;
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + SLOT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        FUNC_ADD: begin
                            if (add_ok) begin
                                slot_next  = (a_idx < b_idx) ? {a_idx, b_idx} : {b_idx, a_idx};
                                add_w_next = s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
                                state_next = ST_ADD_RD;
                            end
                        end
                        FUNC_RUN: begin
                            visited_next    = '0;
                            visited_next[0] = 1'b1;
                            link_valid_next = '0;
                            u_next          = '0;
                            cost_next       = '0;
                            step_next       = '0;
                            cnt_next        = '0;
                            proc_vld_next   = 1'b0;
                            pick_vld_next   = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        FUNC_CLEAR: begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_RD: begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                edge_wr_addr = slot_reg;
                edge_wr_data = {1'b1, add_w_reg};
                edge_wr_en   = !edge_rd_data[EDGE_W-1]
                            || ($signed(add_w_reg) < $signed(edge_rd_data[WEIGHT_W-1:0]));
                state_next   = ST_IDLE;
            end
            ST_SCAN: begin
                proc_vld_next = scan_issue;
                proc_idx_next = scan_idx;
                if (scan_issue) begin
                    cnt_next = cnt_reg + (IDX_W+1)'(1);
                end
                if (proc_vld_reg) begin
                    best_wr_en                    = p_relax;
                    link_valid_next[proc_idx_reg] = p_new_lv;
                    if (p_cand) begin
                        pick_vld_next = 1'b1;
                        pick_idx_next = proc_idx_reg;
                        pick_w_next   = p_new_w;
                    end
                end
                if (!scan_issue) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_node_next   = NODE_W'(u_reg) + NODE_W'(1);
                    m_cost_next   = cost_reg;
                    m_last_next   = last_now;
                    if (last_now) begin
                        state_next = ST_IDLE;
                    end else begin
                        u_next                     = pick_idx_reg;
                        cost_next                  = cost_reg
                            + {{(COST_W-WEIGHT_W){pick_w_reg[WEIGHT_W-1]}}, pick_w_reg};
                        visited_next[pick_idx_reg] = 1'b1;
                        step_next                  = step_reg + IDX_W'(1);
                        cnt_next                   = '0;
                        proc_vld_next              = 1'b0;
                        pick_vld_next              = 1'b0;
                        state_next                 = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            visited_reg    <= '0;
            link_valid_reg <= '0;
            proc_vld_reg   <= 1'b0;
            pick_vld_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            visited_reg    <= visited_next;
            link_valid_reg <= link_valid_next;
            proc_vld_reg   <= proc_vld_next;
            pick_vld_reg   <= pick_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        slot_reg     <= slot_next;
        add_w_reg    <= add_w_next;
        u_reg        <= u_next;
        cost_reg     <= cost_next;
        step_reg     <= step_next;
        cnt_reg      <= cnt_next;
        proc_idx_reg <= proc_idx_next;
        pick_idx_reg <= pick_idx_next;
        pick_w_reg   <= pick_w_next;
        m_node_reg   <= m_node_next;
        m_cost_reg   <= m_cost_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_cost_reg, m_node_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/mst_checker.sv =====
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks on the Prim spanning tree block, bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [mst_pkg::FUNC_W-1:0]   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mst_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tlast
);

    import mst_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass after reset");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_RUN) |=> !s_tready)
        else $error("input ready right after a run transaction");

    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[NODE_W-1:0] != '0)
                  && (m_tdata[NODE_W-1:0] <= NODE_W'(MAX_NODES)))
        else $error("emitted node out of range");

    a_root_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[NODE_W-1:0] == NODE_W'(1))
            |-> (m_tdata[NODE_W+COST_W-1:NODE_W] == '0))
        else $error("root node emitted with nonzero cost");

endmodule

bind min_spanning_tree_prim mst_checker u_mst_checker (.*);

// ===== sim/tb_min_spanning_tree_prim.sv =====
// ----------------------------------------------------------------------------
// tb_min_spanning_tree_prim
// Self-checking bench for the Prim spanning tree block.
// ----------------------------------------------------------------------------
// Loads edges, runs tree builds and clears through the input stream and checks
// each output transaction, field by field, against a behavioral Prim builder
// in the bench or a fixed entry of the directed table. That short table of
// directed commands comes first, then random graphs, mostly small, with one full
// 64-node graph. Both sides idle in phases; one long output hold backs up the input.
// ----------------------------------------------------------------------------
module tb_min_spanning_tree_prim;
    timeunit 1ns;
    timeprecision 1ps;

    import mst_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int ITEM_TARGET = 140;
    localparam int HOLD_CYCLES = 6000;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [COST_W-1:0] cost;
        logic              last;
    } tree_node_t;

    typedef enum { EXP_PRED, EXP_NONE, EXP_ONE } exp_kind_t;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
        exp_kind_t           kind;
        tree_node_t          one;
    } stim_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int  err_count     = 0;
    int  items_sent    = 0;
    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    bit  hold_go       = 1'b0;
    bit  hold_on       = 1'b0;

    tree_node_t tree_expect_q [$];
    tree_node_t build_out_q [$];

    bit                          edge_on [EDGE_DEPTH];
    logic signed [WEIGHT_W-1:0]  edge_w  [EDGE_DEPTH];

    stim_row_t dir_tab [DIR_ROWS] = '{
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_ONE,  '{7'd1, 40'd0, 1'b1}},
        '{FUNC_ADD,   7'd0,   7'd2,   32'd5,        EXP_NONE, '0},
        '{FUNC_ADD,   7'd1,   7'd65,  32'd5,        EXP_NONE, '0},
        '{FUNC_ADD,   7'd127, 7'd1,   32'hFFFFFFFF, EXP_NONE, '0},
        '{FUNC_ADD,   7'd3,   7'd3,   32'd9,        EXP_NONE, '0},
        '{FUNC_SPARE, 7'd127, 7'd127, 32'hFFFFFFFF, EXP_NONE, '0},
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_ONE,  '{7'd1, 40'd0, 1'b1}},
        '{FUNC_ADD,   7'd1,   7'd2,   32'h7FFFFFFF, EXP_PRED, '0},
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_PRED, '0},
        '{FUNC_ADD,   7'd2,   7'd1,   32'h80000000, EXP_PRED, '0},
        '{FUNC_ADD,   7'd1,   7'd2,   32'd0,        EXP_PRED, '0},
        '{FUNC_ADD,   7'd64,  7'd2,   32'h80000000, EXP_PRED, '0},
        '{FUNC_ADD,   7'd1,   7'd3,   32'd7,        EXP_PRED, '0},
        '{FUNC_ADD,   7'd4,   7'd1,   32'd7,        EXP_PRED, '0},
        '{FUNC_ADD,   7'd3,   7'd4,   32'hFFFFFFFB, EXP_PRED, '0},
        '{FUNC_ADD,   7'd2,   7'd3,   32'h7FFFFFFF, EXP_PRED, '0},
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_PRED, '0},
        '{FUNC_ADD,   7'd10,  7'd11,  32'd1,        EXP_PRED, '0},
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_PRED, '0},
        '{FUNC_CLEAR, 7'd0,   7'd0,   32'd0,        EXP_NONE, '0},
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_ONE,  '{7'd1, 40'd0, 1'b1}},
        '{FUNC_ADD,   7'd5,   7'd6,   32'd3,        EXP_PRED, '0},
        '{FUNC_RUN,   7'd0,   7'd0,   32'd0,        EXP_ONE,  '{7'd1, 40'd0, 1'b1}},
        '{FUNC_CLEAR, 7'd0,   7'd0,   32'd0,        EXP_NONE, '0}
    };

    min_spanning_tree_prim uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int edge_slot(int p, int q);
        return (p < q) ? p * MAX_NODES + q : q * MAX_NODES + p;
    endfunction

    // Returns 1 when the command is a valid add, a run or a clear.
    function automatic bit prim_predict(logic [FUNC_W-1:0] f, logic [NODE_W-1:0] a,
                                        logic [NODE_W-1:0] b,
                                        logic signed [WEIGHT_W-1:0] w);
        int                          s;
        int                          u;
        int                          pick;
        int                          cnt;
        bit                          done;
        bit                          reached [MAX_NODES];
        bit                          link_ok [MAX_NODES];
        logic signed [WEIGHT_W-1:0]  link_w  [MAX_NODES];
        logic signed [COST_W-1:0]    cost;
        tree_node_t                  r;

        build_out_q.delete();
        if (f == FUNC_ADD) begin
            if (a < 1 || a > MAX_NODES || b < 1 || b > MAX_NODES || a == b)
                return 1'b0;
            s = edge_slot(int'(a) - 1, int'(b) - 1);
            if (!edge_on[s] || w < edge_w[s]) begin
                edge_w[s]  = w;
                edge_on[s] = 1'b1;
            end
            return 1'b1;
        end
        if (f == FUNC_CLEAR) begin
            foreach (edge_on[i]) edge_on[i] = 1'b0;
            return 1'b1;
        end
        if (f != FUNC_RUN)
            return 1'b0;

        foreach (reached[i]) begin
            reached[i] = 1'b0;
            link_ok[i] = 1'b0;
            link_w[i]  = '0;
        end
        cost = '0;
        u    = 0;
        cnt  = 0;
        done = 1'b0;
        while (!done) begin
            reached[u] = 1'b1;
            r.node = NODE_W'(u + 1);
            r.cost = cost;
            r.last = 1'b0;
            build_out_q.insert(build_out_q.size(), r);
            cnt++;
            for (int v = 0; v < MAX_NODES; v++) begin
                if (reached[v] || v == u) continue;
                s = edge_slot(u, v);
                if (!edge_on[s]) continue;
                if (!link_ok[v] || edge_w[s] < link_w[v]) begin
                    link_ok[v] = 1'b1;
                    link_w[v]  = edge_w[s];
                end
            end
            pick = -1;
            for (int v = 0; v < MAX_NODES; v++) begin
                if (reached[v] || !link_ok[v]) continue;
                if (pick < 0 || link_w[v] < link_w[pick]) pick = v;
            end
            if (pick < 0 || cnt >= MAX_NODES) begin
                done = 1'b1;
            end else begin
                u    = pick;
                cost = cost + link_w[u];
            end
        end
        build_out_q[build_out_q.size() - 1].last = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic set_phase(int p);
        case (p)
            0: begin
                src_idle_pct  = 0;
                snk_stall_pct <= 0;
            end
            1: begin
                src_idle_pct  = 57;
                snk_stall_pct <= 0;
            end
            2: begin
                src_idle_pct  = 0;
                snk_stall_pct <= 57;
            end
            default: begin
                src_idle_pct  = 11;
                snk_stall_pct <= 11;
            end
        endcase
    endtask

    task automatic send_cmd(logic [FUNC_W-1:0] f, logic [NODE_W-1:0] a,
                            logic [NODE_W-1:0] b, logic [WEIGHT_W-1:0] w,
                            exp_kind_t kind, tree_node_t one);
        int gap;

        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_DATA_W - 2 * NODE_W - WEIGHT_W){1'b0}}, w, b, a};
        do @(posedge aclk); while (!s_tready);

        void'(prim_predict(f, a, b, w));
        items_sent++;
        if (kind == EXP_ONE)
            tree_expect_q.insert(tree_expect_q.size(), one);
        else if (kind == EXP_PRED)
            foreach (build_out_q[i])
                tree_expect_q.insert(tree_expect_q.size(), build_out_q[i]);
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return WEIGHT_W'($urandom_range(8)) - 32'd4;
        endcase
    endfunction

    task automatic send_noise();
        logic [NODE_W-1:0] bad;
        logic [NODE_W-1:0] good;

        bad  = $urandom_range(1) ? 7'd0 : NODE_W'($urandom_range(65, 127));
        good = NODE_W'($urandom_range(1, MAX_NODES));
        case ($urandom_range(2))
            0: send_cmd(FUNC_SPARE, NODE_W'($urandom), NODE_W'($urandom), $urandom,
                        EXP_PRED, '0);
            1: begin
                if ($urandom_range(1))
                    send_cmd(FUNC_ADD, bad, good, rand_weight(), EXP_PRED, '0);
                else
                    send_cmd(FUNC_ADD, good, bad, rand_weight(), EXP_PRED, '0);
            end
            default: send_cmd(FUNC_ADD, good, good, rand_weight(), EXP_PRED, '0);
        endcase
    endtask

    always @(posedge aclk) begin
        m_tready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    always @(posedge aclk) begin : mon_blk
        tree_node_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tree_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction node %0d",
                                          m_tdata[NODE_W-1:0]));
            end else begin
                want = tree_expect_q.pop_front();
                if (m_tdata[NODE_W-1:0] !== want.node)
                    report_mismatch($sformatf("node %0d, want %0d",
                                              m_tdata[NODE_W-1:0], want.node));
                if (m_tdata[NODE_W+COST_W-1:NODE_W] !== want.cost)
                    report_mismatch($sformatf("node %0d cost %h, want %h", want.node,
                                              m_tdata[NODE_W+COST_W-1:NODE_W], want.cost));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("node %0d tlast %b, want %b", want.node,
                                              m_tlast, want.last));
            end
        end
    end

    initial begin
        int                round;
        int                n;
        int                k;
        int                j;
        int                tmp;
        int                prev;
        int                order [MAX_NODES-1];
        logic [WEIGHT_W-1:0] w;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        set_phase(0);
        foreach (dir_tab[i])
            send_cmd(dir_tab[i].func, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w,
                     dir_tab[i].kind, dir_tab[i].one);

        round = 0;
        while (items_sent < ITEM_TARGET) begin
            set_phase(round % 4);
            if (round == 2) begin
                send_cmd(FUNC_CLEAR, '0, '0, '0, EXP_PRED, '0);
                foreach (order[i]) order[i] = i + 2;
                for (int i = MAX_NODES - 2; i > 0; i--) begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                prev = 1;
                foreach (order[i]) begin
                    w = $urandom_range(1) ? rand_weight()
                                          : ($urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF);
                    if ($urandom_range(1))
                        send_cmd(FUNC_ADD, NODE_W'(prev), NODE_W'(order[i]), w, EXP_PRED, '0);
                    else
                        send_cmd(FUNC_ADD, NODE_W'(order[i]), NODE_W'(prev), w, EXP_PRED, '0);
                    prev = order[i];
                end
                repeat (8)
                    send_cmd(FUNC_ADD, NODE_W'($urandom_range(1, MAX_NODES)),
                             NODE_W'($urandom_range(1, MAX_NODES)), rand_weight(),
                             EXP_PRED, '0);
                hold_go <= 1'b1;
                send_cmd(FUNC_RUN, '0, '0, '0, EXP_PRED, '0);
            end else begin
                if ($urandom_range(5) == 0)
                    send_cmd(FUNC_CLEAR, '0, '0, '0, EXP_PRED, '0);
                n = $urandom_range(2, 10);
                k = $urandom_range(1, 2 * n);
                repeat (k) begin
                    if ($urandom_range(7) == 0) send_noise();
                    send_cmd(FUNC_ADD, NODE_W'($urandom_range(1, n)),
                             NODE_W'($urandom_range(1, n)), rand_weight(), EXP_PRED, '0);
                end
                send_cmd(FUNC_RUN, '0, '0, '0, EXP_PRED, '0);
            end
            round++;
        end

        s_tvalid <= 1'b0;
        while (tree_expect_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mst_pkg.sv
rtl/core/mst_ram.sv
rtl/core/min_spanning_tree_prim.sv
rtl/core/mst_checker.sv
sim/tb_min_spanning_tree_prim.sv
